/* design/wgm_pkg.sv */
// ----------------------------------------------------------------------------
// wgm_pkg: shared types and constants of the wildcard glob matcher
// Pattern codes, configuration register indexes and the control bundle that
// the top level hands to every position cell.
// ----------------------------------------------------------------------------
package wgm_pkg;

  localparam logic [7:0] STAR_CODE    = 8'h2A;
  localparam logic [7:0] ANY_CODE     = 8'h3F;

  localparam int PATTERN_WORDS = 4;
  localparam int WORD_BYTES    = 8;
  localparam int LEN_W         = 6;
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WORD0  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_WORD1  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WORD2  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_WORD3  = 3'd4;

  typedef struct packed {
    logic advance;
    logic load;
    logic restart;
    logic reclose;
  } wgm_ctrl_t;

endpackage

/* design/wildcard_glob_matcher.sv */
// ----------------------------------------------------------------------------
// wildcard_glob_matcher: streamed whole-text match against a wildcard pattern
// A row of position cells tracks which pattern prefixes explain the text.
// ----------------------------------------------------------------------------
// Usage: write pattern_length and the four pattern words on the cfg port,
// then stream the text one byte per item on the in_ channel. '?' matches
// any one byte, '*' any run of bytes. The item with in_is_last high closes
// the text; an empty text is one item with in_no_byte and in_is_last high.
// One item per cycle is taken while in_stall is low. Each cycle the
// active bits ripple through the position cells once, one cell per pattern
// byte, so a cell chain of min(PATTERN_MAX, 32)+1 positions sets the logic
// depth of a cycle. The match flag of a text enters the result stage once
// its last item is accepted. A result register and one skid entry hold
// results while the receiver stalls; with both full, in_stall rises until
// the receiver takes one. in_stall is high in the cycle of a configuration
// write and in the cycle after it, in which the cells redo the star closure
// of the kept positions for the new pattern.
// Reset empties the result stage, clears the pattern and leaves only
// position zero active.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher import wgm_pkg::*; #(
  parameter int PATTERN_MAX = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_text_byte,
  input  logic                   in_is_last,
  input  logic                   in_no_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_matched
);

  localparam int LIM       = (PATTERN_MAX < PATTERN_WORDS * WORD_BYTES) ?
                             PATTERN_MAX : PATTERN_WORDS * WORD_BYTES;
  localparam int NPOS      = LIM + 1;
  localparam int LEN_SEL_W = $clog2(NPOS);

  logic [LEN_W-1:0]      len_r;
  logic [CFG_DATA_W-1:0] words_r [PATTERN_WORDS];
  logic                  pend_r;
  logic [LEN_SEL_W-1:0]  eff_len;
  logic                  accept;
  logic                  buf_full;
  logic                  matched_val;
  wgm_ctrl_t             ctrl;

  logic [NPOS:0] adv_c;
  logic [NPOS:0] close_c;
  logic [NPOS:0] sclose_c;
  logic [NPOS-1:0] act_v;
  logic [NPOS-1:0] closed_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= '0;
      words_r <= '{default: '0};
      pend_r  <= 1'b0;
    end else begin
      pend_r <= cfg_we;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LENGTH: len_r      <= cfg_data[LEN_W-1:0];
          REG_WORD0:  words_r[0] <= cfg_data;
          REG_WORD1:  words_r[1] <= cfg_data;
          REG_WORD2:  words_r[2] <= cfg_data;
          REG_WORD3:  words_r[3] <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (len_r > LEN_W'(LIM)) begin
      eff_len = LEN_SEL_W'(LIM);
    end else begin
      eff_len = len_r[LEN_SEL_W-1:0];
    end
  end

  assign in_stall = cfg_we | pend_r | buf_full;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    ctrl.advance = accept & ~in_no_byte;
    ctrl.load    = accept;
    ctrl.restart = in_is_last;
    ctrl.reclose = pend_r;
  end

  assign adv_c[0]    = 1'b0;
  assign close_c[0]  = 1'b0;
  assign sclose_c[0] = 1'b0;

  for (genvar i = 0; i < NPOS; i++) begin : g_cell
    logic [7:0] pat_byte;
    if (i < LIM) begin : g_pat
      assign pat_byte = words_r[i / WORD_BYTES][(i % WORD_BYTES) * 8 +: 8];
    end else begin : g_end
      assign pat_byte = 8'h00;
    end

    wgm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .text_byte  (in_text_byte),
      .pat_byte   (pat_byte),
      .en         (LEN_SEL_W'(i) < eff_len),
      .in_range   (LEN_SEL_W'(i) <= eff_len),
      .seed       ((i == 0) ? 1'b1 : 1'b0),
      .adv_in     (adv_c[i]),
      .close_in   (close_c[i]),
      .sclose_in  (sclose_c[i]),
      .adv_out    (adv_c[i+1]),
      .close_out  (close_c[i+1]),
      .sclose_out (sclose_c[i+1]),
      .act        (act_v[i]),
      .closed     (closed_v[i])
    );
  end

  assign matched_val = in_no_byte ? act_v[eff_len] : closed_v[eff_len];

  wgm_out_buf u_out_buf (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (accept & in_is_last),
    .push_matched (matched_val),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_matched  (out_matched),
    .full         (buf_full)
  );

endmodule

/* design/wgm_cell.sv */
// ----------------------------------------------------------------------------
// wgm_cell: one pattern position of the matcher
// Holds the kept bit of its position, the same bit closed over the stars of
// the current pattern and the start-of-text bit, and passes the advance and
// star closure terms to the next position.
// ----------------------------------------------------------------------------
module wgm_cell import wgm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  wgm_ctrl_t ctrl,
  input  logic [7:0] text_byte,
  input  logic [7:0] pat_byte,
  input  logic      en,
  input  logic      in_range,
  input  logic      seed,
  input  logic      adv_in,
  input  logic      close_in,
  input  logic      sclose_in,
  output logic      adv_out,
  output logic      close_out,
  output logic      sclose_out,
  output logic      act,
  output logic      closed
);

  logic act_r, act_nxt;
  logic raw_r, raw_nxt;
  logic start_r, start_nxt;
  logic is_star, hit, nx, sclosed;

  assign is_star = (pat_byte == STAR_CODE);
  assign hit     = (pat_byte == ANY_CODE) || (pat_byte == text_byte);

  assign nx         = ctrl.reclose ? (raw_r & in_range) : ((act_r & en & is_star) | adv_in);
  assign closed     = nx | close_in;
  assign adv_out    = act_r & en & ~is_star & hit;
  assign close_out  = closed & en & is_star;
  assign sclosed    = (seed & in_range) | sclose_in;
  assign sclose_out = sclosed & en & is_star;
  assign act        = act_r;

  always_comb begin
    act_nxt   = act_r;
    raw_nxt   = raw_r;
    start_nxt = start_r;
    if (ctrl.reclose) begin
      act_nxt   = closed;
      start_nxt = sclosed;
    end else if (ctrl.load) begin
      if (ctrl.restart) begin
        act_nxt = start_r;
        raw_nxt = seed;
      end else if (ctrl.advance) begin
        act_nxt = closed;
        raw_nxt = closed;
      end else begin
        raw_nxt = act_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= seed;
      raw_r   <= seed;
      start_r <= seed;
    end else begin
      act_r   <= act_nxt;
      raw_r   <= raw_nxt;
      start_r <= start_nxt;
    end
  end

endmodule

/* design/wgm_out_buf.sv */
// ----------------------------------------------------------------------------
// wgm_out_buf: result register with one skid entry
// Keeps a result while the receiver stalls and takes one more behind it.
// ----------------------------------------------------------------------------
module wgm_out_buf (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  logic push_matched,
  input  logic out_stall,
  output logic out_valid,
  output logic out_matched,
  output logic full
);

  logic out_valid_r, out_valid_nxt;
  logic out_matched_r, out_matched_nxt;
  logic skid_valid_r, skid_valid_nxt;
  logic skid_matched_r, skid_matched_nxt;

  always_comb begin
    out_valid_nxt    = out_valid_r;
    out_matched_nxt  = out_matched_r;
    skid_valid_nxt   = skid_valid_r;
    skid_matched_nxt = skid_matched_r;
    if (out_valid_r && out_stall) begin
      if (push) begin
        skid_valid_nxt   = 1'b1;
        skid_matched_nxt = push_matched;
      end
    end else if (skid_valid_r) begin
      out_valid_nxt   = 1'b1;
      out_matched_nxt = skid_matched_r;
      skid_valid_nxt  = 1'b0;
    end else begin
      out_valid_nxt   = push;
      out_matched_nxt = push_matched;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_matched_r  <= out_matched_nxt;
    skid_matched_r <= skid_matched_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;
  assign full        = skid_valid_r;

endmodule

/* design/wgm_checker.sv */
// ----------------------------------------------------------------------------
// wgm_checker: port-level checks of the wildcard glob matcher
// Watches the channels and the configuration port of the top level.
// ----------------------------------------------------------------------------
module wgm_checker (
  input logic clk,
  input logic rst_n,
  input logic cfg_we,
  input logic in_valid,
  input logic in_stall,
  input logic in_is_last,
  input logic out_valid,
  input logic out_stall,
  input logic out_matched
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result channel is not empty after reset.");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_is_last |=> out_valid)
    else $error("No result follows an accepted last item.");

  a_cfg_stall: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> in_stall)
    else $error("An item was taken in the cycle after a configuration write.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_matched))
    else $error("A stalled result changed or vanished.");

endmodule

bind wildcard_glob_matcher wgm_checker u_wgm_checker (.*);
